// ===== design/tbrp_pkg.sv =====
// Shared types and constants for the tracking reply parser.
`default_nettype none

package tbrp_pkg;

  typedef enum logic [3:0] {
    PH_START0,
    PH_START1,
    PH_HEADER,
    PH_COUNT,
    PH_HID,
    PH_HSTAT,
    PH_POSE,
    PH_PORT,
    PH_SYS0,
    PH_SYS1,
    PH_DONE,
    PH_IGNORE
  } phase_e;

  // Commands from the front parser to the back end.
  typedef enum logic [2:0] {
    OP_POSE_BYTE,  // shift a pose byte into the word assembler
    OP_POSE_WORD,  // shift, then store the finished word at idx
    OP_POSE_EMIT,  // emit a pose record, data holds the handle id
    OP_FRAME,      // emit frame complete, data holds system status
    OP_BAD,        // emit bad start sequence
    OP_TRUNC       // emit truncated frame
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [2:0]  idx;
    logic [15:0] data;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  localparam logic [15:0] START_SEQ    = 16'hA5C4;
  localparam logic [7:0]  STATUS_VALID = 8'h01;
  localparam logic [5:0]  HEADER_SKIP  = 6'd4;
  localparam logic [5:0]  PORT_SKIP    = 6'd8;
  localparam logic [5:0]  POSE_BYTES   = 6'd32;
  localparam logic [5:0]  POSE_STORED  = 6'd28;
  localparam int          NUM_WORDS    = 7;

  localparam logic [1:0] KIND_POSE  = 2'd0;
  localparam logic [1:0] KIND_FRAME = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;
  localparam logic [1:0] KIND_TRUNC = 2'd3;

endpackage

`default_nettype wire

// ===== design/tbrp_front.sv =====
// Front parser: walks the reply byte by byte and issues back-end commands.
`default_nettype none

module tbrp_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [7:0]     reply_byte_i,
  input  wire logic           end_of_reply_i,
  output tbrp_pkg::push_t     push_o
);

  tbrp_pkg::phase_e phase_q, phase_d;
  logic [5:0] cnt_q, cnt_d;
  logic [6:0] hl_q, hl_d;
  logic [7:0] handle_q, handle_d;
  logic [7:0] low_q, low_d;

  logic [5:0] cnt_inc;
  logic [6:0] hl_dec;

  assign cnt_inc = cnt_q + 6'd1;
  assign hl_dec  = (hl_q != 7'd0) ? hl_q - 7'd1 : 7'd0;

  // Next state
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    hl_d     = hl_q;
    handle_d = handle_q;
    low_d    = low_q;
    if (accept_i) begin
      case (phase_q)
        tbrp_pkg::PH_START0: begin
          low_d   = reply_byte_i;
          phase_d = tbrp_pkg::PH_START1;
        end
        tbrp_pkg::PH_START1: begin
          if ({reply_byte_i, low_q} == tbrp_pkg::START_SEQ) begin
            phase_d = tbrp_pkg::PH_HEADER;
            cnt_d   = 6'd0;
          end else begin
            phase_d = tbrp_pkg::PH_IGNORE;
          end
        end
        tbrp_pkg::PH_HEADER: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= tbrp_pkg::HEADER_SKIP) begin
            cnt_d   = 6'd0;
            phase_d = tbrp_pkg::PH_COUNT;
          end
        end
        tbrp_pkg::PH_COUNT: begin
          // negative count means no handles
          hl_d    = reply_byte_i[7] ? 7'd0 : reply_byte_i[6:0];
          phase_d = (reply_byte_i[7] || reply_byte_i[6:0] == 7'd0) ?
                    tbrp_pkg::PH_SYS0 : tbrp_pkg::PH_HID;
        end
        tbrp_pkg::PH_HID: begin
          handle_d = reply_byte_i;
          phase_d  = tbrp_pkg::PH_HSTAT;
        end
        tbrp_pkg::PH_HSTAT: begin
          cnt_d   = 6'd0;
          phase_d = (reply_byte_i == tbrp_pkg::STATUS_VALID) ?
                    tbrp_pkg::PH_POSE : tbrp_pkg::PH_PORT;
        end
        tbrp_pkg::PH_POSE: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= tbrp_pkg::POSE_BYTES) begin
            cnt_d   = 6'd0;
            phase_d = tbrp_pkg::PH_PORT;
          end
        end
        tbrp_pkg::PH_PORT: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= tbrp_pkg::PORT_SKIP) begin
            cnt_d   = 6'd0;
            hl_d    = hl_dec;
            phase_d = (hl_dec == 7'd0) ? tbrp_pkg::PH_SYS0 : tbrp_pkg::PH_HID;
          end
        end
        tbrp_pkg::PH_SYS0: begin
          low_d   = reply_byte_i;
          phase_d = tbrp_pkg::PH_SYS1;
        end
        tbrp_pkg::PH_SYS1: begin
          phase_d = tbrp_pkg::PH_DONE;
        end
        tbrp_pkg::PH_IGNORE: begin
          phase_d = tbrp_pkg::PH_IGNORE;
        end
        default: begin
          phase_d = tbrp_pkg::PH_DONE;
        end
      endcase
      if (end_of_reply_i) begin
        phase_d  = tbrp_pkg::PH_START0;
        cnt_d    = 6'd0;
        hl_d     = 7'd0;
        handle_d = 8'd0;
        low_d    = 8'd0;
      end
    end
  end

  // Command outputs
  always_comb begin
    logic terminal;
    terminal     = 1'b0;
    push_o.valid = 1'b0;
    push_o.entry = '{op: tbrp_pkg::OP_POSE_BYTE, idx: cnt_q[4:2],
                     data: {8'd0, reply_byte_i}};
    if (accept_i) begin
      case (phase_q)
        tbrp_pkg::PH_START1: begin
          if ({reply_byte_i, low_q} != tbrp_pkg::START_SEQ) begin
            terminal           = 1'b1;
            push_o.valid       = 1'b1;
            push_o.entry.op    = tbrp_pkg::OP_BAD;
          end
        end
        tbrp_pkg::PH_POSE: begin
          if (cnt_inc >= tbrp_pkg::POSE_BYTES) begin
            push_o.valid      = 1'b1;
            push_o.entry.op   = tbrp_pkg::OP_POSE_EMIT;
            push_o.entry.data = {8'd0, handle_q};
          end else if (cnt_q < tbrp_pkg::POSE_STORED) begin
            // error word bytes are dropped
            push_o.valid    = 1'b1;
            push_o.entry.op = (cnt_q[1:0] == 2'd3) ? tbrp_pkg::OP_POSE_WORD
                                                   : tbrp_pkg::OP_POSE_BYTE;
          end
        end
        tbrp_pkg::PH_SYS1: begin
          terminal          = 1'b1;
          push_o.valid      = 1'b1;
          push_o.entry.op   = tbrp_pkg::OP_FRAME;
          push_o.entry.data = {reply_byte_i, low_q};
        end
        tbrp_pkg::PH_DONE, tbrp_pkg::PH_IGNORE: begin
          terminal = 1'b1;
        end
        default: begin
          terminal = 1'b0;
        end
      endcase
      if (end_of_reply_i && !terminal) begin
        push_o.valid    = 1'b1;
        push_o.entry.op = tbrp_pkg::OP_TRUNC;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= tbrp_pkg::PH_START0;
      cnt_q    <= 6'd0;
      hl_q     <= 7'd0;
      handle_q <= 8'd0;
      low_q    <= 8'd0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      hl_q     <= hl_d;
      handle_q <= handle_d;
      low_q    <= low_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/tbrp_queue.sv =====
// Two-entry command queue between front parser and back end.
`default_nettype none

module tbrp_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tbrp_pkg::push_t push_i,
  input  wire logic            pop_i,
  output tbrp_pkg::entry_t     head_o,
  output logic                 not_empty_o,
  output logic                 full_o
);

  tbrp_pkg::entry_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_pop;

  assign not_empty_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign head_o      = mem_q[rd_ptr_q];
  assign do_pop      = pop_i && not_empty_o;

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i.valid, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/tbrp_back.sv =====
// Back end: assembles pose words and drives the registered result port.
`default_nettype none

module tbrp_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tbrp_pkg::entry_t  head_i,
  input  wire logic              not_empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             result_kind_o,
  output logic [7:0]             handle_id_o,
  output logic [31:0]            rot_w_o,
  output logic [31:0]            rot_x_o,
  output logic [31:0]            rot_y_o,
  output logic [31:0]            rot_z_o,
  output logic [31:0]            pos_x_o,
  output logic [31:0]            pos_y_o,
  output logic [31:0]            pos_z_o,
  output logic [15:0]            system_status_o
);

  logic [31:0] word_q;
  logic [31:0] words_q [tbrp_pkg::NUM_WORDS];
  logic        out_valid_q;
  logic        emits;
  logic        slot_free;
  logic [31:0] word_next;

  assign emits = (head_i.op == tbrp_pkg::OP_POSE_EMIT) || (head_i.op == tbrp_pkg::OP_FRAME) ||
                 (head_i.op == tbrp_pkg::OP_BAD) || (head_i.op == tbrp_pkg::OP_TRUNC);
  assign slot_free   = !out_valid_q || out_ready_i;
  assign pop_o       = not_empty_i && (!emits || slot_free);
  assign out_valid_o = out_valid_q;
  assign word_next   = {head_i.data[7:0], word_q[31:8]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && emits) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      case (head_i.op)
        tbrp_pkg::OP_POSE_BYTE: begin
          word_q <= word_next;
        end
        tbrp_pkg::OP_POSE_WORD: begin
          word_q              <= word_next;
          words_q[head_i.idx] <= word_next;
        end
        tbrp_pkg::OP_POSE_EMIT: begin
          result_kind_o   <= tbrp_pkg::KIND_POSE;
          handle_id_o     <= head_i.data[7:0];
          rot_w_o         <= words_q[0];
          rot_x_o         <= words_q[1];
          rot_y_o         <= words_q[2];
          rot_z_o         <= words_q[3];
          pos_x_o         <= words_q[4];
          pos_y_o         <= words_q[5];
          pos_z_o         <= words_q[6];
          system_status_o <= 16'd0;
        end
        tbrp_pkg::OP_FRAME: begin
          result_kind_o   <= tbrp_pkg::KIND_FRAME;
          handle_id_o     <= 8'd0;
          rot_w_o         <= 32'd0;
          rot_x_o         <= 32'd0;
          rot_y_o         <= 32'd0;
          rot_z_o         <= 32'd0;
          pos_x_o         <= 32'd0;
          pos_y_o         <= 32'd0;
          pos_z_o         <= 32'd0;
          system_status_o <= head_i.data;
        end
        default: begin
          // bad start or truncated frame: kind only
          result_kind_o   <= (head_i.op == tbrp_pkg::OP_BAD) ? tbrp_pkg::KIND_BAD
                                                            : tbrp_pkg::KIND_TRUNC;
          handle_id_o     <= 8'd0;
          rot_w_o         <= 32'd0;
          rot_x_o         <= 32'd0;
          rot_y_o         <= 32'd0;
          rot_z_o         <= 32'd0;
          pos_x_o         <= 32'd0;
          pos_y_o         <= 32'd0;
          pos_z_o         <= 32'd0;
          system_status_o <= 16'd0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/tracker_binary_reply_parser_core.sv =====
// Top level of the binary tracking reply parser.
//
// Takes one reply byte per request (little-endian multi-byte values, a flag
// on the final byte), checks the A5C4 start sequence, skips the header, and
// walks the handle list. Each handle with status 0x01 yields a pose record
// holding the raw float words of the quaternion and translation; the system
// status at the end yields a frame-complete result. A wrong start sequence
// yields a bad-start result and the rest of that reply is dropped; a final
// byte that arrives before the frame is complete yields a truncated-frame
// result. Rate: one byte per cycle while the queue has room; commands pass
// through the queue to the output register. The front parser and back end
// are split by a two-entry command queue, so the input keeps flowing while
// a finished result waits on out_ready_i; the input only stalls once that
// queue has filled behind a stalled result. No reset sweep is needed.
`default_nettype none

module tracker_binary_reply_parser_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  reply_byte_i,
  input  wire logic        end_of_reply_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       result_kind_o,
  output logic [7:0]       handle_id_o,
  output logic [31:0]      rot_w_o,
  output logic [31:0]      rot_x_o,
  output logic [31:0]      rot_y_o,
  output logic [31:0]      rot_z_o,
  output logic [31:0]      pos_x_o,
  output logic [31:0]      pos_y_o,
  output logic [31:0]      pos_z_o,
  output logic [15:0]      system_status_o
);

  tbrp_pkg::push_t  push;
  tbrp_pkg::entry_t head;
  logic             not_empty;
  logic             full;
  logic             pop;
  logic             accept;

  // A byte is taken whenever the queue has room for its command.
  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;

  tbrp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .reply_byte_i   (reply_byte_i),
    .end_of_reply_i (end_of_reply_i),
    .push_o         (push)
  );

  tbrp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pop_i       (pop),
    .head_o      (head),
    .not_empty_o (not_empty),
    .full_o      (full)
  );

  // Back end holds the word assembler, the seven stored pose words and the
  // output register.
  tbrp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .not_empty_i     (not_empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_kind_o   (result_kind_o),
    .handle_id_o     (handle_id_o),
    .rot_w_o         (rot_w_o),
    .rot_x_o         (rot_x_o),
    .rot_y_o         (rot_y_o),
    .rot_z_o         (rot_z_o),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .pos_z_o         (pos_z_o),
    .system_status_o (system_status_o)
  );

endmodule

`default_nettype wire

// ===== verif/tracker_binary_reply_parser_core_tb.sv =====
// Self-checking testbench for the binary tracking reply parser core.
module tracker_binary_reply_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbrp_pkg::*;

  // Cycles with no request and no result moving before the run is declared hung.
  localparam int STUCK_LIMIT = 2000;
  // Settle time after the last result, covering the path through the two-entry
  // command queue and the output register, taken several times over.
  localparam int TAIL_CYCLES = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  handle_id;
    logic [31:0] rot_w;
    logic [31:0] rot_x;
    logic [31:0] rot_y;
    logic [31:0] rot_z;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [15:0] system_status;
  } reply_result_t;

  // One row of the directed table: a byte sent reps times, the flag and the
  // typed-in result (if any) apply to the last copy only.
  typedef struct packed {
    logic [7:0]    data;
    logic          last;
    logic [5:0]    reps;
    logic          typed;
    reply_result_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  reply_byte_i = 8'h00;
  logic        end_of_reply_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [7:0]  handle_id_o;
  logic [31:0] rot_w_o;
  logic [31:0] rot_x_o;
  logic [31:0] rot_y_o;
  logic [31:0] rot_z_o;
  logic [31:0] pos_x_o;
  logic [31:0] pos_y_o;
  logic [31:0] pos_z_o;
  logic [15:0] system_status_o;

  tracker_binary_reply_parser_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .reply_byte_i   (reply_byte_i),
    .end_of_reply_i (end_of_reply_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .handle_id_o    (handle_id_o),
    .rot_w_o        (rot_w_o),
    .rot_x_o        (rot_x_o),
    .rot_y_o        (rot_y_o),
    .rot_z_o        (rot_z_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .pos_z_o        (pos_z_o),
    .system_status_o(system_status_o)
  );

  always #4 clk_i = ~clk_i;

  // Parser shadow state, advanced once per accepted request.
  phase_e      rx_phase;
  logic [5:0]  rx_count;
  logic [6:0]  rx_handles;
  logic [7:0]  rx_handle;
  logic [31:0] rx_shift;
  logic [31:0] rx_words [7];
  logic [7:0]  rx_low;

  reply_result_t awaited_results[$];
  stim_row_t     directed_rows[$];

  int          mismatches = 0;
  int          bytes_sent = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int          stuck_cycles = 0;

  // Idle mix per random phase: none, sender only, receiver only, both.
  int unsigned gap_by_phase   [4] = '{0, 49, 0, 13};
  int unsigned stall_by_phase [4] = '{0, 0, 49, 13};

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic void reset_parser();
    rx_phase   = PH_START0;
    rx_count   = '0;
    rx_handles = '0;
    rx_handle  = '0;
    rx_shift   = '0;
    rx_low     = '0;
    foreach (rx_words[i]) rx_words[i] = '0;
  endfunction

  // Advances the shadow parser by one byte; returns 1 when a result is due.
  function automatic bit parse_reply_byte(input logic [7:0] b, input logic last,
                                          output reply_result_t res);
    bit emit;
    bit closed;  // frame finished, bad start or ignoring: no truncation
    emit   = 1'b0;
    closed = 1'b0;
    res    = '0;
    case (rx_phase)
      PH_START0: begin
        rx_low   = b;
        rx_phase = PH_START1;
      end
      PH_START1: begin
        if ({b, rx_low} == START_SEQ) begin
          rx_phase = PH_HEADER;
          rx_count = '0;
        end else begin
          res.kind = KIND_BAD;
          emit     = 1'b1;
          closed   = 1'b1;
          rx_phase = PH_IGNORE;
        end
      end
      PH_HEADER: begin
        rx_count = rx_count + 6'd1;
        if (rx_count >= HEADER_SKIP) begin
          rx_count = '0;
          rx_phase = PH_COUNT;
        end
      end
      PH_COUNT: begin
        // count is signed: anything with the top bit set means no handles
        rx_handles = b[7] ? 7'd0 : b[6:0];
        if (rx_handles == 7'd0) rx_phase = PH_SYS0;
        else rx_phase = PH_HID;
      end
      PH_HID: begin
        rx_handle = b;
        rx_phase  = PH_HSTAT;
      end
      PH_HSTAT: begin
        rx_count = '0;
        if (b == STATUS_VALID) rx_phase = PH_POSE;
        else rx_phase = PH_PORT;
      end
      PH_POSE: begin
        rx_shift = {b, rx_shift[31:8]};
        // eighth word is the error estimate and is not kept
        if (rx_count[1:0] == 2'd3 && rx_count[4:2] != 3'd7)
          rx_words[rx_count[4:2]] = rx_shift;
        rx_count = rx_count + 6'd1;
        if (rx_count >= POSE_BYTES) begin
          res.kind      = KIND_POSE;
          res.handle_id = rx_handle;
          res.rot_w     = rx_words[0];
          res.rot_x     = rx_words[1];
          res.rot_y     = rx_words[2];
          res.rot_z     = rx_words[3];
          res.pos_x     = rx_words[4];
          res.pos_y     = rx_words[5];
          res.pos_z     = rx_words[6];
          emit          = 1'b1;
          rx_count      = '0;
          rx_phase      = PH_PORT;
        end
      end
      PH_PORT: begin
        rx_count = rx_count + 6'd1;
        if (rx_count >= PORT_SKIP) begin
          rx_count = '0;
          if (rx_handles != 7'd0) rx_handles = rx_handles - 7'd1;
          if (rx_handles == 7'd0) rx_phase = PH_SYS0;
          else rx_phase = PH_HID;
        end
      end
      PH_SYS0: begin
        rx_low   = b;
        rx_phase = PH_SYS1;
      end
      PH_SYS1: begin
        res.kind          = KIND_FRAME;
        res.system_status = {b, rx_low};
        emit              = 1'b1;
        closed            = 1'b1;
        rx_phase          = PH_DONE;
      end
      default: begin
        closed = 1'b1;
        if (rx_phase != PH_IGNORE) rx_phase = PH_DONE;
      end
    endcase
    if (last) begin
      // an early final byte replaces whatever this byte would have produced
      if (!closed) begin
        res      = '0;
        res.kind = KIND_TRUNC;
        emit     = 1'b1;
      end
      reset_parser();
    end
    return emit;
  endfunction

  function automatic reply_result_t kind_of(input logic [1:0] k);
    reply_result_t r;
    r      = '0;
    r.kind = k;
    return r;
  endfunction

  function automatic reply_result_t frame_of(input logic [15:0] status);
    reply_result_t r;
    r               = '0;
    r.kind          = KIND_FRAME;
    r.system_status = status;
    return r;
  endfunction

  // Pose whose seven words all carry the same value.
  function automatic reply_result_t pose_of(input logic [7:0] id, input logic [31:0] w);
    reply_result_t r;
    r           = '0;
    r.kind      = KIND_POSE;
    r.handle_id = id;
    r.rot_w     = w;
    r.rot_x     = w;
    r.rot_y     = w;
    r.rot_z     = w;
    r.pos_x     = w;
    r.pos_y     = w;
    r.pos_z     = w;
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] data, input logic last = 1'b0,
                                  input int unsigned reps = 1, input logic typed = 1'b0,
                                  input reply_result_t want = '0);
    stim_row_t row;
    row.data  = data;
    row.last  = last;
    row.reps  = 6'(reps);
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Sends one request, holding it until accepted, then books the result it
  // should cause. A typed-in result takes the place of the prediction.
  task automatic send_byte(input logic [7:0] b, input logic last,
                           input logic typed = 1'b0, input reply_result_t want = '0);
    reply_result_t predicted;
    bit            due;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    reply_byte_i   <= b;
    end_of_reply_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    due = parse_reply_byte(b, last, predicted);
    if (typed) awaited_results.push_back(want);
    else if (due) awaited_results.push_back(predicted);
    bytes_sent++;
  endtask

  // Stops sending until every booked result has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  // One random reply: mostly well-formed frames with random content, some cut
  // short, some with a bad start sequence, a few pure noise.
  task automatic send_reply(input bit pause_mid);
    logic [7:0]  q[$];
    int unsigned style;
    int unsigned count;
    int unsigned cut;
    logic [7:0]  status;
    logic [15:0] start;
    style = $urandom_range(99);
    if (style < 85) begin
      q.push_back(START_SEQ[7:0]);
      q.push_back(START_SEQ[15:8]);
      repeat (4) q.push_back(rand_byte());
      if ($urandom_range(99) < 15) count = $urandom_range(255, 128);
      else count = $urandom_range(3);
      q.push_back(8'(count));
      if (count < 128) begin
        repeat (count) begin
          q.push_back(rand_byte());
          status = ($urandom_range(99) < 65) ? STATUS_VALID : rand_byte();
          q.push_back(status);
          if (status == STATUS_VALID) repeat (POSE_BYTES) q.push_back(rand_byte());
          repeat (PORT_SKIP) q.push_back(rand_byte());
        end
      end
      repeat (2) q.push_back(rand_byte());
      repeat ($urandom_range(3)) q.push_back(rand_byte());
      if (style >= 70) begin
        cut = $urandom_range(q.size(), 1);
        while (q.size() > cut) void'(q.pop_back());
      end
    end else if (style < 95) begin
      do begin
        start = 16'($urandom);
        if ($urandom_range(1) == 1) start[7:0] = START_SEQ[7:0];
      end while (start == START_SEQ);
      q.push_back(start[7:0]);
      q.push_back(start[15:8]);
      repeat ($urandom_range(3)) q.push_back(rand_byte());
    end else begin
      repeat ($urandom_range(6, 1)) q.push_back(rand_byte());
    end
    foreach (q[i]) begin
      if (pause_mid && i == q.size() / 2) drain();
      send_byte(q[i], i == q.size() - 1);
    end
  endtask

  // Result side: random stalls, each accepted result against the oldest booking.
  always @(posedge clk_i) begin : result_check
    reply_result_t oldest;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: kind %0d", result_kind_o);
        mismatches++;
      end else begin
        oldest = awaited_results.pop_front();
        check_field("result_kind", 32'(oldest.kind), 32'(result_kind_o));
        check_field("handle_id", 32'(oldest.handle_id), 32'(handle_id_o));
        check_field("rot_w", oldest.rot_w, rot_w_o);
        check_field("rot_x", oldest.rot_x, rot_x_o);
        check_field("rot_y", oldest.rot_y, rot_y_o);
        check_field("rot_z", oldest.rot_z, rot_z_o);
        check_field("pos_x", oldest.pos_x, pos_x_o);
        check_field("pos_y", oldest.pos_y, pos_y_o);
        check_field("pos_z", oldest.pos_z, pos_z_o);
        check_field("system_status", 32'(oldest.system_status), 32'(system_status_o));
      end
    end
    out_ready_i <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // Hang detection: nothing moving on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $error("no request or result moved for %0d cycles", STUCK_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    int        bytes_at_start;
    bit        first;
    reset_parser();

    // Negative handle count gives an empty frame; a byte after the frame end
    // is dropped, and its final flag raises no truncation.
    add_row(8'hC4);
    add_row(8'hA5);
    add_row(8'h00, 1'b0, 4);
    add_row(8'h80);
    add_row(8'h34);
    add_row(8'h12, 1'b0, 1, 1'b1, frame_of(16'h1234));
    add_row(8'hFF, 1'b1);
    // Two poses at the extremes of id and data, final flag on the status high byte.
    add_row(8'hC4);
    add_row(8'hA5);
    add_row(8'hFF, 1'b0, 4);
    add_row(8'h02);
    add_row(8'h00);
    add_row(STATUS_VALID);
    add_row(8'h00, 1'b0, 32, 1'b1, pose_of(8'h00, 32'h0000_0000));
    add_row(8'h00, 1'b0, 8);
    add_row(8'hFF);
    add_row(STATUS_VALID);
    add_row(8'hFF, 1'b0, 32, 1'b1, pose_of(8'hFF, 32'hFFFF_FFFF));
    add_row(8'hFF, 1'b0, 8);
    add_row(8'hFF);
    add_row(8'hFF, 1'b1, 1, 1'b1, frame_of(16'hFFFF));
    // Bad start: the rest of the reply is dropped.
    add_row(8'hC4);
    add_row(8'hA4, 1'b0, 1, 1'b1, kind_of(KIND_BAD));
    add_row(8'hC4, 1'b1);
    // Final flag on the very first byte.
    add_row(8'hC4, 1'b1, 1, 1'b1, kind_of(KIND_TRUNC));
    // Largest positive count; a handle with a non-valid status is skipped,
    // then the final flag lands on the byte that would finish a pose.
    add_row(8'hC4);
    add_row(8'hA5);
    add_row(8'h5A, 1'b0, 4);
    add_row(8'h7F);
    add_row(8'h7F);
    add_row(8'hFE);
    add_row(8'h33, 1'b0, 8);
    add_row(8'h05);
    add_row(STATUS_VALID);
    add_row(8'hAA, 1'b0, 31);
    add_row(8'h55, 1'b1, 1, 1'b1, kind_of(KIND_TRUNC));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      for (int k = 1; k <= row.reps; k++) begin
        if (k == row.reps) send_byte(row.data, row.last, row.typed, row.want);
        else send_byte(row.data, 1'b0);
      end
    end
    drain();

    // Random phases of at least 130 bytes each; the first reply of each pauses
    // halfway until the output side has caught up.
    for (int p = 0; p < 4; p++) begin
      gap_pct        = gap_by_phase[p];
      stall_pct      = stall_by_phase[p];
      bytes_at_start = bytes_sent;
      first          = 1'b1;
      while (bytes_sent - bytes_at_start < 130) begin
        send_reply(first);
        first = 1'b0;
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
